// File: sv/rida_pkg.sv
package rida_pkg;

    // request kinds
    localparam logic [2:0] KIND_ALLOC        = 3'd0;
    localparam logic [2:0] KIND_ALLOC_COMMIT = 3'd1;
    localparam logic [2:0] KIND_SEED         = 3'd2;
    localparam logic [2:0] KIND_SET_COMMIT   = 3'd3;
    localparam logic [2:0] KIND_SET_CONTEXT  = 3'd4;
    localparam logic [2:0] KIND_READ         = 3'd5;

    // result status codes
    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_DISABLED     = 3'd1;
    localparam logic [2:0] STATUS_CLOCK_BEHIND = 3'd2;
    localparam logic [2:0] STATUS_SECOND_FULL  = 3'd3;
    localparam logic [2:0] STATUS_EXHAUSTED    = 3'd4;
    localparam logic [2:0] STATUS_BLOCKED      = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_FORMAT  = 2'd1;
    localparam logic [1:0] CFG_WARN    = 2'd2;

    localparam logic       FORMAT_COUNTER = 1'b1;
    localparam logic [47:0] MAX48         = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] SEQ_LAST      = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] epoch_seconds;
        logic [3:0]  stripe;
        logic [63:0] value;
        logic [63:0] log_position;
        logic        log_position_present;
        logic [31:0] replication_generation;
        logic        generation_present;
    } item_t;

    typedef struct packed {
        logic [63:0] context_id;
        logic [63:0] commit_id;
        logic [63:0] commit_position;
        logic [31:0] commit_gen;
    } state_t;

    typedef struct packed {
        logic        enabled;
        logic        id_format;
        logic [47:0] warn_threshold;
    } cfg_t;

    typedef struct packed {
        logic [63:0] new_id;
        logic [2:0]  status;
        logic        low_id_warning;
    } result_t;

    // ordering of ids: seconds first, then bits 31..4; stripe ignored
    function automatic logic id_before(input logic [63:0] a, input logic [63:0] b);
        return {a[63:32], a[31:4]} < {b[63:32], b[31:4]};
    endfunction

endpackage

// File: sv/record_id_allocator.sv
// record id allocator: one request per transfer (allocate, allocate for commit,
// seed, set commit, set context, read) and exactly one result per request.
// a request is taken into an input register, worked out in one short
// combinational pass and lands in a result register together with a snapshot
// of the context and commit state after it; the state itself is updated at
// that same edge, so the next request already sees it. sustained rate is one
// request per clock while out_stall stays low; a request passes through the
// input register and then the result register before its result is valid, and
// out_stall can hold it in either. the result register lets a new request into
// the input register while a finished result still waits.
// configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only be changed while no request is in flight; index 3 is ignored.
// no clearing pass after reset: all state resets at once.
module record_id_allocator
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,

    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] epoch_seconds,
    input  logic [3:0]  stripe,
    input  logic [63:0] value,
    input  logic [63:0] log_position,
    input  logic        log_position_present,
    input  logic [31:0] replication_generation,
    input  logic        generation_present,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] new_id,
    output logic [2:0]  status,
    output logic        low_id_warning,
    output logic [63:0] current_context,
    output logic [63:0] last_commit_id,
    output logic [63:0] last_commit_position,
    output logic [31:0] last_commit_generation
);

    // configuration registers
    rida_pkg::cfg_t    cfg_reg;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    rida_pkg::item_t   item_reg;

    // allocator state
    rida_pkg::state_t  state_reg;
    rida_pkg::state_t  state_next;

    // result register: result plus state snapshot after the step
    logic              out_valid_reg;
    logic              out_valid_next;
    rida_pkg::result_t res_reg;
    rida_pkg::result_t res_next;
    rida_pkg::state_t  snap_reg;

    logic              in_accept;
    logic              out_free;
    logic              step_fire;

    // result register can load when empty or when its transfer happens now
    assign out_free  = !out_valid_reg || !out_stall;
    // a request moves from the input register to the result register
    assign step_fire = in_valid_reg && out_free;
    // input register holds only while its item is blocked
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next  = in_accept || (in_valid_reg && !out_free);
    assign out_valid_next = step_fire || (out_valid_reg && out_stall);

    rida_core u_core
    (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .result     (res_next),
        .state_next (state_next)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rida_pkg::CFG_ENABLED: cfg_reg.enabled        <= cfg_data[0];
                rida_pkg::CFG_FORMAT:  cfg_reg.id_format      <= cfg_data[0];
                rida_pkg::CFG_WARN:    cfg_reg.warn_threshold <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // handshake state and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.kind                   <= kind;
            item_reg.epoch_seconds          <= epoch_seconds;
            item_reg.stripe                 <= stripe;
            item_reg.value                  <= value;
            item_reg.log_position           <= log_position;
            item_reg.log_position_present   <= log_position_present;
            item_reg.replication_generation <= replication_generation;
            item_reg.generation_present     <= generation_present;
        end
        if (step_fire)
        begin
            res_reg  <= res_next;
            snap_reg <= state_next;
        end
    end

    assign out_valid              = out_valid_reg;
    assign new_id                 = res_reg.new_id;
    assign status                 = res_reg.status;
    assign low_id_warning         = res_reg.low_id_warning;
    assign current_context        = snap_reg.context_id;
    assign last_commit_id         = snap_reg.commit_id;
    assign last_commit_position   = snap_reg.commit_position;
    assign last_commit_generation = snap_reg.commit_gen;

    // stored commit id never moves backward
    a_commit_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> !rida_pkg::id_before(state_reg.commit_id, $past(state_reg.commit_id)))
        else $error("commit id moved backward");

    // a request that leaves the input register always becomes a result
    a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> out_valid_reg)
        else $error("request lost between input and result register");

    // failed requests other than blocked ones give no id and no warning
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status != rida_pkg::STATUS_OK && status != rida_pkg::STATUS_BLOCKED
        |-> new_id == 64'd0 && !low_id_warning)
        else $error("failed request carries an id or warning");

    // warning only comes with an issued id
    a_warn_with_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && low_id_warning |-> new_id != 64'd0)
        else $error("low id warning without an issued id");

endmodule

// File: sv/rida_core.sv
module rida_core
(
    input  rida_pkg::item_t   item,
    input  rida_pkg::state_t  state,
    input  rida_pkg::cfg_t    cfg,
    output rida_pkg::result_t result,
    output rida_pkg::state_t  state_next
);

    logic [63:0] cnt_base;
    logic        cnt_full;
    logic [47:0] cnt_inc;
    logic        warn48;
    logic [3:0]  stripe48;
    logic [63:0] id48;
    logic [31:0] ctime;
    logic        same_second;
    logic        clock_behind;
    logic        second_full;
    logic [15:0] seq;
    logic [63:0] id_time;

    // counter path, shared by 48-bit allocation and seed
    assign cnt_base = (item.kind == rida_pkg::KIND_SEED && item.value != 64'd0)
                      ? item.value : {16'd0, state.context_id[63:16]};
    assign cnt_full = cnt_base >= {16'd0, rida_pkg::MAX48};
    assign cnt_inc  = cnt_base[47:0] + 48'd1;
    // max48 minus count is the bitwise complement in 48 bits
    assign warn48   = (cfg.warn_threshold != 48'd0) && (~cnt_inc <= cfg.warn_threshold);
    assign stripe48 = (item.kind == rida_pkg::KIND_SEED) ? 4'd0 : item.stripe;
    assign id48     = {cnt_inc, 12'd0, stripe48};

    // time path
    assign ctime        = state.context_id[63:32];
    assign same_second  = ctime == item.epoch_seconds;
    assign clock_behind = ctime > item.epoch_seconds;
    assign second_full  = same_second && (state.context_id[31:16] == rida_pkg::SEQ_LAST);
    assign seq          = same_second ? state.context_id[31:16] + 16'd1 : 16'd1;
    assign id_time      = {item.epoch_seconds, seq, 12'd0, item.stripe};

    always_comb
    begin
        result     = '0;
        state_next = state;
        unique case (item.kind)
            rida_pkg::KIND_ALLOC, rida_pkg::KIND_ALLOC_COMMIT:
            begin
                if (!cfg.enabled)
                begin
                    result.status = rida_pkg::STATUS_DISABLED;
                end
                else if (cfg.id_format == rida_pkg::FORMAT_COUNTER)
                begin
                    if (cnt_full)
                    begin
                        result.status = rida_pkg::STATUS_EXHAUSTED;
                    end
                    else
                    begin
                        result.new_id         = id48;
                        result.low_id_warning = warn48;
                        state_next.context_id = id48;
                    end
                end
                else
                begin
                    if (clock_behind)
                    begin
                        result.status = rida_pkg::STATUS_CLOCK_BEHIND;
                    end
                    else if (second_full)
                    begin
                        result.status = rida_pkg::STATUS_SECOND_FULL;
                    end
                    else
                    begin
                        result.new_id         = id_time;
                        state_next.context_id = id_time;
                    end
                end
                if (cfg.enabled && result.status == rida_pkg::STATUS_OK
                    && item.kind == rida_pkg::KIND_ALLOC_COMMIT)
                begin
                    if (rida_pkg::id_before(result.new_id, state.commit_id))
                    begin
                        result.status = rida_pkg::STATUS_BLOCKED;
                    end
                    else
                    begin
                        state_next.commit_id       = result.new_id;
                        state_next.commit_position = item.log_position;
                        state_next.commit_gen      = item.replication_generation;
                    end
                end
            end
            rida_pkg::KIND_SEED:
            begin
                if (cnt_full)
                begin
                    result.status = rida_pkg::STATUS_EXHAUSTED;
                end
                else
                begin
                    result.new_id         = id48;
                    result.low_id_warning = warn48;
                    state_next.context_id = id48;
                end
            end
            rida_pkg::KIND_SET_COMMIT:
            begin
                if (rida_pkg::id_before(item.value, state.commit_id))
                begin
                    result.status = rida_pkg::STATUS_BLOCKED;
                end
                else
                begin
                    state_next.commit_id = item.value;
                    if (item.log_position_present)
                    begin
                        state_next.commit_position = item.log_position;
                    end
                    if (item.generation_present)
                    begin
                        state_next.commit_gen = item.replication_generation;
                    end
                    if (!rida_pkg::id_before(item.value, state.context_id))
                    begin
                        state_next.context_id = item.value;
                    end
                end
            end
            rida_pkg::KIND_SET_CONTEXT:
            begin
                if (rida_pkg::id_before(item.value, state.context_id))
                begin
                    result.status = rida_pkg::STATUS_BLOCKED;
                end
                else
                begin
                    state_next.context_id = item.value;
                end
            end
            rida_pkg::KIND_READ:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule
